[hdl/svjp_pkg.sv]
package svjp_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned FRAC = 24;
  localparam int unsigned SPOT_W = 48;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned EXP_TERMS = 13;

  localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [SPOT_W-1:0] SPOT_MAX = {SPOT_W{1'b1}};

  typedef enum logic [2:0] {
    REG_START_LOG = 3'd0,
    REG_START_VAR = 3'd1,
    REG_DRIFT     = 3'd2,
    REG_ROOT_STEP = 3'd3,
    REG_REVERSION = 3'd4,
    REG_LONG_VAR  = 3'd5,
    REG_VV_SPOT   = 3'd6,
    REG_VV_INDEP  = 3'd7
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DT,
    ST_HVDT,
    ST_SVR,
    ST_DIFF,
    ST_ZVA,
    ST_ZVB,
    ST_REV,
    ST_SVZ,
    ST_UPD,
    ST_EXP_P,
    ST_EXP_T,
    ST_EXP_SER,
    ST_EXP_DIV,
    ST_EXP_OUT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [31:0] start_log;
    logic [30:0] start_var;
    logic signed [31:0] drift;
    logic [30:0] root_step;
    logic [30:0] reversion;
    logic [30:0] long_var;
    logic signed [31:0] vv_spot;
    logic [30:0] vv_indep;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Floor of (2^32 - 1) / k for the series term index k. The quotient taken from
  // a product with this value is at most one below the exact floor quotient.
  function automatic logic [31:0] recip_q32(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd1:    r = 32'hFFFF_FFFF;
      4'd2:    r = 32'h7FFF_FFFF;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h3FFF_FFFF;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h1FFF_FFFF;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      4'd13:   r = 32'h13B1_3B13;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/stochastic_vol_jump_path_step_unit.sv]
// Channel   Direction  Payload
// s_axis    in         tdata: normal_spot, normal_indep, jump_log_total; tuser: final_step,
//                      mirror_path
// m_axis    out        tdata: terminal_spot, terminal_log_price
// cfg       in         cfg_addr_i register index, cfg_data_i value
// A step runs from one accepted item to the next through the bit-serial square root (32
// iterations plus start and hand-off), eight passes through the shared multiplier, the
// state update and the return to idle.
// A final step then adds the exp: two multiplies, 13 series terms of two multiplies each
// (the second by the reciprocal of the term index), the shift and the output load.
// Reset clears control and config registers, logp and var; it arms a start load for step one.
// The input is not ready while a step runs; a result waiting on m_axis_tready_i only holds
// the sequencer once the next final step reaches its output state.
module stochastic_vol_jump_path_step_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // normal_spot[31:0], normal_indep[63:32], jump_log_total[95:64]
  input  logic [95:0] s_axis_tdata_i,
  // final_step[0], mirror_path[1]
  input  logic [1:0] s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // terminal_spot[47:0], terminal_log_price[79:48]
  output logic [79:0] m_axis_tdata_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [svjp_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [31:0] cfg_data_i
);
  import svjp_pkg::*;

  cfg_t cfg_q;
  state_e state_q, state_d;
  logic signed [31:0] logp_q, logp_d, var_q, var_d;
  logic load_q, load_d;
  logic signed [31:0] z1_q, z1_d, z2_q, z2_d, jump_q, jump_d;
  logic fin_q, fin_d;
  logic signed [31:0] vplus_q, vplus_d, sv_q, sv_d, dt_q, dt_d, hv_q, hv_d;
  logic signed [31:0] t1_q, t1_d, zv_q, zv_d, rev_q, rev_d, svz_q, svz_d;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic mul_wait_q, mul_wait_d;
  logic sq_start, sq_busy;
  logic [31:0] sq_root;
  logic [63:0] term_q, term_d, sum_q, sum_d, tfr_q, tfr_d;
  logic [3:0] k_q, k_d;
  logic [31:0] dq_q, dq_d;
  logic signed [31:0] n_q, n_d;
  logic [47:0] spot_q, spot_d;
  logic ovalid_q, ovalid_d;
  logic [79:0] odata_q, odata_d;
  logic signed [31:0] ms;
  logic signed [63:0] s;
  logic [31:0] quo;
  logic [35:0] quo_k, dv_rem;

  svjp_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));
  svjp_isqrt u_sqrt (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(sq_start),
    .x_i({vplus_q[30:0], 31'd0} >> 7), .busy_o(sq_busy), .root_o(sq_root));

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o = odata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_START_LOG: cfg_q.start_log <= cfg_data_i;
        REG_START_VAR: cfg_q.start_var <= cfg_data_i[30:0];
        REG_DRIFT:     cfg_q.drift <= cfg_data_i;
        REG_ROOT_STEP: cfg_q.root_step <= cfg_data_i[30:0];
        REG_REVERSION: cfg_q.reversion <= cfg_data_i[30:0];
        REG_LONG_VAR:  cfg_q.long_var <= cfg_data_i[30:0];
        REG_VV_SPOT:   cfg_q.vv_spot <= cfg_data_i;
        REG_VV_INDEP:  cfg_q.vv_indep <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q; logp_d = logp_q; var_d = var_q; load_d = load_q;
    z1_d = z1_q; z2_d = z2_q; jump_d = jump_q; fin_d = fin_q;
    vplus_d = vplus_q; sv_d = sv_q; dt_d = dt_q; hv_d = hv_q; t1_d = t1_q;
    zv_d = zv_q; rev_d = rev_q; svz_d = svz_q; mul_wait_d = 1'b0;
    term_d = term_q; sum_d = sum_q; tfr_d = tfr_q; k_d = k_q;
    dq_d = dq_q; n_d = n_q; spot_d = spot_q;
    ovalid_d = ovalid_q; odata_d = odata_q;
    mul_a = '0; mul_b = '0; sq_start = 1'b0;
    ms = sat32(signed'(mul_p[65:FRAC]));
    s = '0;
    quo = '0;
    quo_k = '0;
    dv_rem = '0;
    if (ovalid_q && m_axis_tready_i) ovalid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i && s_axis_tready_o) begin
          z1_d = s_axis_tdata_i[31:0];
          z2_d = s_axis_tdata_i[63:32];
          if (s_axis_tuser_i[1]) begin
            z1_d = sat32(-64'(signed'(s_axis_tdata_i[31:0])));
            z2_d = sat32(-64'(signed'(s_axis_tdata_i[63:32])));
          end
          jump_d = s_axis_tdata_i[95:64];
          fin_d = s_axis_tuser_i[0];
          if (load_q) begin
            logp_d = cfg_q.start_log;
            var_d = {1'b0, cfg_q.start_var};
            load_d = 1'b0;
            vplus_d = {1'b0, cfg_q.start_var};
          end else begin
            vplus_d = var_q[31] ? '0 : var_q;
          end
          state_d = ST_SQRT;
          mul_wait_d = 1'b1;
        end
      end
      ST_SQRT: begin
        if (mul_wait_q) sq_start = 1'b1;
        else if (!sq_busy) begin
          sv_d = sq_root;
          state_d = ST_DT;
        end
      end
      ST_DT: begin
        mul_a = {2'b0, cfg_q.root_step}; mul_b = {2'b0, cfg_q.root_step};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin dt_d = ms; state_d = ST_HVDT; end
      end
      ST_HVDT: begin
        mul_a = {vplus_q[31], vplus_q}; mul_b = {dt_q[31], dt_q};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin hv_d = ms >>> 1; state_d = ST_SVR; end
      end
      ST_SVR: begin
        mul_a = {sv_q[31], sv_q}; mul_b = {2'b0, cfg_q.root_step};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin t1_d = ms; state_d = ST_DIFF; end
      end
      ST_DIFF: begin
        mul_a = {t1_q[31], t1_q}; mul_b = {z1_q[31], z1_q};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin t1_d = ms; state_d = ST_ZVA; end
      end
      ST_ZVA: begin
        mul_a = {cfg_q.vv_spot[31], cfg_q.vv_spot}; mul_b = {z1_q[31], z1_q};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin zv_d = ms; state_d = ST_ZVB; end
      end
      ST_ZVB: begin
        mul_a = {2'b0, cfg_q.vv_indep}; mul_b = {z2_q[31], z2_q};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin
          zv_d = sat32(64'(zv_q) + 64'(ms));
          rev_d = sat32({{33{1'b0}}, cfg_q.long_var} - 64'(vplus_q));
          state_d = ST_REV;
        end
      end
      ST_REV: begin
        mul_a = {2'b0, cfg_q.reversion}; mul_b = {rev_q[31], rev_q};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin rev_d = ms; state_d = ST_SVZ; end
      end
      ST_SVZ: begin
        mul_a = {sv_q[31], sv_q}; mul_b = {zv_q[31], zv_q};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin svz_d = ms; state_d = ST_UPD; end
      end
      ST_UPD: begin
        logp_d = sat32(64'(logp_q) + 64'(cfg_q.drift) - 64'(hv_q) + 64'(t1_q)
          + 64'(jump_q));
        var_d = sat32(64'(var_q) + 64'(rev_q) + 64'(svz_q));
        if (fin_q) begin
          load_d = 1'b1;
          state_d = ST_EXP_P;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EXP_P: begin
        mul_a = {logp_q[31], logp_q}; mul_b = {LOG2E_Q30[31], LOG2E_Q30};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin
          n_d = {{22{mul_p[63]}}, mul_p[63:54]};
          tfr_d = {32'd0, mul_p[53:22]};
          state_d = ST_EXP_T;
        end
      end
      ST_EXP_T: begin
        mul_a = {1'b0, tfr_q[31:0]}; mul_b = {1'b0, LN2_Q32};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin
          tfr_d = {32'd0, mul_p[63:32]};
          term_d = 64'h1_0000_0000;
          sum_d = 64'h1_0000_0000;
          k_d = 4'd1;
          state_d = ST_EXP_SER;
        end
      end
      ST_EXP_SER: begin
        mul_a = {1'b0, term_q[31:0]}; mul_b = {1'b0, tfr_q[31:0]};
        if (term_q[32]) mul_a = {1'b0, 32'hFFFF_FFFF};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin
          dq_d = term_q[32] ? tfr_q[31:0] : mul_p[63:32];
          state_d = ST_EXP_DIV;
        end
      end
      ST_EXP_DIV: begin
        mul_a = {1'b0, dq_q}; mul_b = {1'b0, recip_q32(k_q)};
        mul_wait_d = !mul_wait_q;
        if (mul_wait_q) begin
          quo = mul_p[63:32];
          quo_k = {4'd0, quo} * {32'd0, k_q};
          dv_rem = {4'd0, dq_q} - quo_k;
          if (dv_rem >= {32'd0, k_q}) quo = quo + 32'd1;
          term_d = {32'd0, quo};
          sum_d = sum_q + {32'd0, quo};
          if (k_q == 4'(EXP_TERMS)) state_d = ST_EXP_OUT;
          else begin
            k_d = k_q + 4'd1;
            state_d = ST_EXP_SER;
          end
        end
      end
      ST_EXP_OUT: begin
        s = 64'(n_q) - 64'sd8;
        if (s >= 0) begin
          if (s >= 31) spot_d = SPOT_MAX;
          else if ((sum_q << s[4:0]) > 64'(SPOT_MAX)) spot_d = SPOT_MAX;
          else spot_d = 48'(sum_q << s[4:0]);
        end else if (-s >= 64) spot_d = '0;
        else spot_d = 48'(sum_q >> 6'(-s));
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q) begin
          odata_d = {logp_q, spot_q};
          ovalid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      load_q <= 1'b1;
      ovalid_q <= 1'b0;
      mul_wait_q <= 1'b0;
      logp_q <= '0;
      var_q <= '0;
    end else begin
      state_q <= state_d;
      load_q <= load_d;
      ovalid_q <= ovalid_d;
      mul_wait_q <= mul_wait_d;
      logp_q <= logp_d;
      var_q <= var_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z1_q <= z1_d; z2_q <= z2_d; jump_q <= jump_d; fin_q <= fin_d;
    vplus_q <= vplus_d; sv_q <= sv_d; dt_q <= dt_d; hv_q <= hv_d; t1_q <= t1_d;
    zv_q <= zv_d; rev_q <= rev_d; svz_q <= svz_d;
    term_q <= term_d; sum_q <= sum_d; tfr_q <= tfr_d; k_q <= k_d;
    dq_q <= dq_d; n_q <= n_d; spot_q <= spot_d;
    odata_q <= odata_d;
  end

endmodule

[hdl/svjp_mul.sv]
module svjp_mul (
  input  logic clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end
endmodule

[hdl/svjp_isqrt.sv]
module svjp_isqrt (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [61:0] x_i,
  output logic busy_o,
  output logic [31:0] root_o
);
  import svjp_pkg::*;

  logic [63:0] x_q, x_d;
  logic [63:0] r_q, r_d;
  logic [63:0] bit_q, bit_d;
  logic busy_q, busy_d;

  always_comb begin
    x_d = x_q;
    r_d = r_q;
    bit_d = bit_q;
    busy_d = busy_q;
    if (start_i) begin
      x_d = {2'b00, x_i};
      r_d = '0;
      bit_d = 64'h4000_0000_0000_0000;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (x_q >= r_q + bit_q) begin
        x_d = x_q - (r_q + bit_q);
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    r_q <= r_d;
    bit_q <= bit_d;
  end

  assign busy_o = busy_q;
  assign root_o = r_q[31:0];
endmodule
